// ===== rtl/core/btpe_pkg.sv =====
// ----------------------------------------------------------------------------
// btpe_pkg
// shared types and constants of the tensor bernstein evaluator
// ----------------------------------------------------------------------------
package btpe_pkg;

  localparam int NUM_DIMS = 4;
  localparam int REG_IDX_W = 3;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [REG_IDX_W-1:0] REG_LOWER_0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_UPPER_0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOWER_1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_UPPER_1 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LOWER_2 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_UPPER_2 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_LOWER_3 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_UPPER_3 = 3'd7;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // fixed-point unit-interval value, 65536 is one
  typedef logic [16:0] uq16_t;

  typedef struct packed {
    logic start;
    logic [31:0] num;
    logic [31:0] span;
  } div_req_t;

  typedef struct packed {
    logic done;
    uq16_t quot;
  } div_rsp_t;

  // binomial coefficient c(n,m), n up to 7
  function automatic logic [6:0] binom(input logic [2:0] n, input logic [2:0] m);
    logic [13:0] c;
    c = 14'd1;
    for (int k = 0; k < 7; k++) begin
      if (k < int'(m)) begin
        c = 14'((c * 14'(int'(n) - k)) / 14'(k + 1));
      end
    end
    return c[6:0];
  endfunction

endpackage

// ===== rtl/core/btpe_ram.sv =====
// ----------------------------------------------------------------------------
// btpe_ram
// generic ram with one write port and one registered read port
// ----------------------------------------------------------------------------
module btpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/btpe_lane.sv =====
// ----------------------------------------------------------------------------
// btpe_lane
// one input lane: scaling to u with a restoring divider, then the basis
// values b_0..b_order computed by one shared multiplier over cycles
// ----------------------------------------------------------------------------
module btpe_lane #(
  parameter int ORDER = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] sample,
  input  logic signed [31:0] lower,
  input  logic signed [31:0] upper,
  output logic               done,
  output btpe_pkg::uq16_t    basis [ORDER+1]
);
  localparam int MW = $clog2(ORDER + 1);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_DIV = 4'b0010, S_BAS = 4'b0100, S_DONE = 4'b1000
  } state_t;
  state_t state;
  logic signed [32:0] span, num;
  logic [32:0] dspan;
  logic [48:0] q;
  logic [33:0] rem;
  logic [5:0] cnt;
  btpe_pkg::uq16_t u, t, fac;
  logic [MW-1:0] m;
  logic [3:0] k;
  logic [33:0] prod;
  logic [23:0] scaled;
  logic [33:0] tr;
  logic [6:0] bin_tab [ORDER+1];

  for (genvar g = 0; g <= ORDER; g++) begin : g_bin
    assign bin_tab[g] = btpe_pkg::binom(3'(ORDER), 3'(g));
  end

  assign span = 33'(upper) - 33'(lower);
  assign num = 33'(sample) - 33'(lower);
  assign tr = {rem[32:0], q[48]} - {1'b0, dspan};
  assign fac = (32'(k) < 32'(m)) ? u : (btpe_pkg::ONE_Q16 - u);
  assign prod = 34'(t) * 34'(fac) + 34'd32768;
  assign scaled = 24'(t) * 24'(bin_tab[m]);

  // scaling by clamp or by shift-subtract division (one quotient bit per cycle, 49 steps), then the basis steps
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (start) begin
          m <= '0; k <= '0; t <= btpe_pkg::ONE_Q16;
          dspan <= span; rem <= '0; q <= {num[32:0], 16'd0}; cnt <= 6'd49;
          if ($signed(43'(span) * 43'sd1000) < 43'sd65536) begin
            u <= btpe_pkg::ONE_Q16; state <= S_BAS;
          end else if (num <= 0) begin
            u <= '0; state <= S_BAS;
          end else if (num >= span) begin
            u <= btpe_pkg::ONE_Q16; state <= S_BAS;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!tr[33]) begin
            rem <= tr; q <= {q[47:0], 1'b1};
          end else begin
            rem <= {rem[32:0], q[48]}; q <= {q[47:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) state <= S_BAS;
        end
        S_BAS: begin
          if (k == 4'(ORDER)) begin
            basis[m] <= (scaled > 24'(btpe_pkg::ONE_Q16)) ? btpe_pkg::ONE_Q16 : scaled[16:0];
            k <= '0; t <= btpe_pkg::ONE_Q16;
            if (m == MW'(ORDER)) state <= S_DONE;
            m <= m + MW'(1);
          end else begin
            t <= prod[32:16]; k <= k + 4'd1;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (state == S_DIV && cnt == 6'd1) begin
        u <= (!tr[33]) ? {q[15:0], 1'b1} : {q[15:0], 1'b0};
      end
    end
  end
  assign done = (state == S_DONE);
endmodule

// ===== rtl/core/bernstein_tensor_poly_eval_4d_unit.sv =====
// ----------------------------------------------------------------------------
// bernstein_tensor_poly_eval_4d_unit
// 4-d tensor bernstein polynomial evaluator
// ----------------------------------------------------------------------------
// usage: pulse start for one item while busy is low. command 0 loads
// coeff_value at coeff_index in the accepting cycle, busy stays low, no
// result. command 1 evaluates: each of four lanes scales its sample
// (shift-subtract divider, skipped when u is clamped or forced to one)
// and builds its basis ((order+1)^2 multiplier steps plus a done state),
// then one multiply-accumulate walks the (order+1)^4 coefficients, one
// per cycle, followed by the drain of the memory and product pipeline and
// an output state. busy stays high through all of this, and the sweep
// over the coefficient ram takes most of it.
// the result shows on poly_value and saturated with valid high for one
// cycle, the cycle in which busy falls; the receiver cannot stall.
// configuration writes take effect at once and belong between items.
// reset restores default bounds; the coefficient ram is not cleared.
// ----------------------------------------------------------------------------
module bernstein_tensor_poly_eval_4d_unit #(
  parameter int ORDER = 3,
  parameter int COEFF_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               command,
  input  logic [7:0]         coeff_index,
  input  logic signed [31:0] coeff_value,
  input  logic signed [31:0] sample_0,
  input  logic signed [31:0] sample_1,
  input  logic signed [31:0] sample_2,
  input  logic signed [31:0] sample_3,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               valid,
  output logic signed [47:0] poly_value,
  output logic               saturated
);
  localparam int AW = $clog2(COEFF_DEPTH);
  localparam int N1 = ORDER + 1;
  localparam int NT = N1 * N1 * N1 * N1;
  localparam int TW = $clog2(NT + 1);
  localparam int BW = $clog2(N1);

  logic signed [31:0] lo [4];
  logic signed [31:0] hi [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < 4; d++) begin
        lo[d] <= '0;
        hi[d] <= 32'sd65536;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        btpe_pkg::REG_LOWER_0: lo[0] <= cfg_data;
        btpe_pkg::REG_UPPER_0: hi[0] <= cfg_data;
        btpe_pkg::REG_LOWER_1: lo[1] <= cfg_data;
        btpe_pkg::REG_UPPER_1: hi[1] <= cfg_data;
        btpe_pkg::REG_LOWER_2: lo[2] <= cfg_data;
        btpe_pkg::REG_UPPER_2: hi[2] <= cfg_data;
        btpe_pkg::REG_LOWER_3: lo[3] <= cfg_data;
        btpe_pkg::REG_UPPER_3: hi[3] <= cfg_data;
      endcase
    end
  end

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LANE = 4'b0010,
    S_ACC  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;
  state_t state;

  logic [3:0] ldone;
  logic [3:0] lseen;
  logic signed [31:0] smp [4];
  btpe_pkg::uq16_t bas [4][N1];
  assign smp[0] = sample_0;
  assign smp[1] = sample_1;
  assign smp[2] = sample_2;
  assign smp[3] = sample_3;

  logic lstart;
  assign lstart = (state == S_IDLE) && start && (command == btpe_pkg::CMD_EVAL);

  // lanes: scale and basis, one divider per lane
  for (genvar d = 0; d < 4; d++) begin : g_lane
    btpe_lane #(.ORDER(ORDER)) u_lane (
      .clk, .rst, .start(lstart), .sample(smp[d]), .lower(lo[d]), .upper(hi[d]),
      .done(ldone[d]), .basis(bas[d])
    );
  end

  // term walk
  logic [TW-1:0] term;
  logic [AW-1:0] raddr;
  logic signed [31:0] rdata;
  logic we;
  assign we = (state == S_IDLE) && start && (command == btpe_pkg::CMD_LOAD)
              && (32'(coeff_index) < 32'(COEFF_DEPTH));

  btpe_ram #(.WIDTH(32), .DEPTH(COEFF_DEPTH)) u_ram (
    .clk, .we, .waddr(AW'(coeff_index)), .wdata(coeff_value),
    .raddr, .rdata
  );

  // digit counters of term in base order+1
  logic [BW-1:0] ii, jj, kk, ll;
  assign raddr = AW'(term);

  // product pipeline over the basis values
  logic v1, v2, v3;
  logic [33:0] p1, p2;
  btpe_pkg::uq16_t bk1, bl1, bl2, pa, pb;
  logic [33:0] p3;
  btpe_pkg::uq16_t pc, pfin;
  logic in1, in2, in3;
  logic signed [31:0] cf, cf2, cf3;
  logic signed [81:0] acc;
  logic signed [49:0] prodc;

  assign p1 = 34'(bas[0][ii]) * 34'(bas[1][jj]) + 34'd32768;
  assign p2 = 34'(pa) * 34'(bk1) + 34'd32768;
  assign p3 = 34'(pb) * 34'(bl2) + 34'd32768;

  always_ff @(posedge clk) begin
    pa <= p1[32:16];
    bk1 <= bas[2][kk];
    bl1 <= bas[3][ll];
    in1 <= (32'(term) < 32'(COEFF_DEPTH));
    pb <= p2[32:16];
    bl2 <= bl1;
    in2 <= in1;
    pc <= p3[32:16];
    in3 <= in2;
    cf <= rdata;
    cf2 <= cf;
    cf3 <= cf2;
    pfin <= pc;
    prodc <= 50'(cf3) * $signed({1'b0, pfin});
  end

  logic v4, v5, v6, in4, in5;
  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6} <= '0;
    end else begin
      v1 <= (state == S_ACC) && (term < TW'(NT));
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
    in4 <= in3;
    in5 <= in4;
  end

  // rounding and saturation
  logic signed [81:0] s;
  logic signed [65:0] r;
  assign s = acc + 82'sd32768;
  assign r = 66'(s >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
      lseen <= '0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        S_IDLE: if (lstart) begin
          state <= S_LANE;
          lseen <= '0;
        end
        S_LANE: begin
          lseen <= lseen | ldone;
          if ((lseen | ldone) == 4'hf) begin
            state <= S_ACC;
            term <= '0;
            ii <= '0;
            jj <= '0;
            kk <= '0;
            ll <= '0;
            acc <= '0;
          end
        end
        S_ACC: begin
          if (term < TW'(NT)) begin
            term <= term + TW'(1);
            ll <= (ll == BW'(ORDER)) ? '0 : ll + BW'(1);
            if (ll == BW'(ORDER)) begin
              kk <= (kk == BW'(ORDER)) ? '0 : kk + BW'(1);
              if (kk == BW'(ORDER)) begin
                jj <= (jj == BW'(ORDER)) ? '0 : jj + BW'(1);
                if (jj == BW'(ORDER)) ii <= (ii == BW'(ORDER)) ? '0 : ii + BW'(1);
              end
            end
          end
          if (v5 && in5) acc <= acc + 82'(prodc);
          if (term == TW'(NT) && !v1 && !v2 && !v3 && !v4 && !v5 && !v6) state <= S_OUT;
        end
        S_OUT: begin
          valid <= 1'b1;
          if (r > 66'sh7FFFFFFFFFFF) begin
            poly_value <= 48'sh7FFFFFFFFFFF; saturated <= 1'b1;
          end else if (r < -66'sh800000000000) begin
            poly_value <= 48'sh800000000000; saturated <= 1'b1;
          end else begin
            poly_value <= r[47:0]; saturated <= 1'b0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  a_valid_pulse: assert property (@(posedge clk) disable iff (rst) valid |=> !valid)
    else $error("valid held");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |-> busy) else $error("busy low in acc");
  a_out_from_acc: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(state == S_OUT)) else $error("valid without out state");
endmodule
